FILE: src/learning_switch_spanning_tree_core_assert.svh
// Assertion macros for the learning switch core
`ifndef LEARNING_SWITCH_SPANNING_TREE_CORE_ASSERT_SVH
`define LEARNING_SWITCH_SPANNING_TREE_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define LSST_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define LSST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lsst_pkg.sv
// Shared types and constants of the learning switch core
`timescale 1ns / 1ps

package lsst_pkg;

    localparam int CMD_W      = 2;
    localparam int PORT_W     = 3;
    localparam int ADDR_W     = 8;
    localparam int MASK_W     = 8;
    localparam int ID_W       = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_DATA   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADVERT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    localparam logic [1:0] KIND_UNICAST = 2'd0;
    localparam logic [1:0] KIND_FLOOD   = 2'd1;
    localparam logic [1:0] KIND_TREE    = 2'd2;
    localparam logic [1:0] KIND_ADVERT  = 2'd3;

    localparam logic [1:0] SENDER_HOST   = 2'd0;
    localparam logic [1:0] SENDER_SWITCH = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORTS_IN_USE = 1'd1;

    localparam logic [ID_W-1:0] NODE_ID_RST      = 8'd0;
    localparam logic [3:0]      PORTS_IN_USE_RST = 4'd8;

    typedef struct packed {
        logic [1:0]        child_pad;
        logic              child_flag;
        logic [1:0]        sender_kind;
        logic [7:0]        heard_root_dist;
        logic [ID_W-1:0]   heard_root_id;
        logic [ADDR_W-1:0] dst_addr;
        logic [ADDR_W-1:0] src_addr;
        logic [PORT_W-1:0] in_port;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        pad;
        logic              table_full;
        logic              learned;
        logic              parent_valid;
        logic [PORT_W-1:0] parent_port;
        logic [7:0]        advert_root_dist;
        logic [ID_W-1:0]   advert_root_id;
        logic [MASK_W-1:0] out_port_mask;
    } t_out_word;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } t_entry;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_data;
        logic in_drop;
        logic cnt_zero;
        logic last_read;
        logic out_free;
    } t_dp_status;

endpackage

FILE: src/lsst_ctrl.sv
// Controller state machine of the learning switch core
`timescale 1ns / 1ps

module lsst_ctrl
    import lsst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_LAST   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    priority if (i_status.in_drop) begin
                        n_state = S_IDLE;
                    end else if (i_status.in_data && !i_status.cnt_zero) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.last_read) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: src/lsst_dpath.sv
// Datapath of the learning switch core: address table, tree state, result register
`timescale 1ns / 1ps

module lsst_dpath
    import lsst_pkg::*;
#(
    parameter int NUM_PORTS     = 8,
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CMD_W-1:0]      i_in_cmd,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [1:0]            o_out_kind,
    output logic [OUT_DATA_W-1:0] o_out_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TABLE_ENTRIES);
    localparam logic [4:0]       NPORTS  = 5'(NUM_PORTS);

    t_entry r_mem [TABLE_ENTRIES];

    t_in_word          r_item;
    logic [CMD_W-1:0]  r_cmd;
    logic [IDX_W-1:0]  r_idx;
    logic              r_rd_vld;
    t_entry            r_rd_word;
    logic              r_hit;
    logic              r_known;
    logic [PORT_W-1:0] r_target;
    logic [CNT_W-1:0]  r_count;

    logic [3:0]        r_ports_in_use;
    logic [ID_W-1:0]   r_root;
    logic [7:0]        r_dist;
    logic [PORT_W-1:0] r_par;
    logic              r_pknown;
    logic [MASK_W-1:0] r_tree;

    logic              r_out_valid;
    logic [1:0]        r_out_kind;
    t_out_word         r_out_word;

    logic [ID_W-1:0]   n_root;
    logic [7:0]        n_dist;
    logic [PORT_W-1:0] n_par;
    logic              n_pknown;
    logic [MASK_W-1:0] n_tree;
    logic [1:0]        n_kind;
    logic [MASK_W-1:0] n_mask;
    logic              n_learn;
    logic              n_full;

    logic [4:0]        w_nports;
    logic [MASK_W-1:0] w_in_use;
    logic [8:0]        w_sum;
    logic [7:0]        w_sat;
    logic              w_take;
    logic              w_room;

    assign o_status.in_data   = (i_in_cmd == CMD_DATA);
    assign o_status.in_drop   = (i_in_cmd == CMD_NONE);
    assign o_status.cnt_zero  = (r_count == '0);
    assign o_status.last_read = (CNT_W'(r_idx) + CNT_W'(1) == r_count);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_data  = r_out_word;

    always_comb begin
        w_nports = ({1'b0, r_ports_in_use} > NPORTS) ? NPORTS : {1'b0, r_ports_in_use};
        for (int b = 0; b < MASK_W; b++) begin
            w_in_use[b] = (5'(b) < w_nports);
        end
    end

    assign w_sum  = {1'b0, r_item.heard_root_dist} + 9'd1;
    assign w_sat  = w_sum[8] ? 8'hFF : w_sum[7:0];
    assign w_room = (r_count < CNT_MAX);

    always_comb begin
        n_root   = r_root;
        n_dist   = r_dist;
        n_par    = r_par;
        n_pknown = r_pknown;
        n_tree   = r_tree;
        n_kind   = KIND_ADVERT;
        n_mask   = '0;
        n_learn  = 1'b0;
        n_full   = 1'b0;
        w_take   = 1'b0;
        unique case (r_cmd)
            CMD_DATA: begin
                if (r_hit) begin
                    n_kind = KIND_UNICAST;
                    n_mask = MASK_W'(1) << r_target;
                end else begin
                    n_kind = KIND_FLOOD;
                    n_mask = r_tree & w_in_use & ~(MASK_W'(1) << r_item.in_port);
                end
                n_learn = !r_known && w_room;
                n_full  = !r_known && !w_room;
            end
            CMD_TREE: begin
                n_kind = KIND_TREE;
                if (r_item.sender_kind == SENDER_SWITCH) begin
                    if (r_item.heard_root_id < r_root) begin
                        n_root = r_item.heard_root_id;
                        w_take = 1'b1;
                    end else if (r_item.heard_root_id == r_root &&
                                 {1'b0, r_dist} > w_sum) begin
                        w_take = 1'b1;
                    end
                end
                if (w_take) begin
                    if (r_pknown) begin
                        n_tree[r_par] = 1'b0;
                    end
                    n_par    = r_item.in_port;
                    n_pknown = 1'b1;
                    n_dist   = w_sat;
                end
                if (r_item.sender_kind == SENDER_HOST) begin
                    n_tree[r_item.in_port] = 1'b1;
                end else if (r_item.sender_kind == SENDER_SWITCH &&
                             ((n_pknown && n_par == r_item.in_port) ||
                              r_item.child_flag)) begin
                    n_tree[r_item.in_port] = 1'b1;
                end else begin
                    n_tree[r_item.in_port] = 1'b0;
                end
            end
            CMD_ADVERT: begin
                n_kind = KIND_ADVERT;
                n_mask = w_in_use;
            end
            default: begin
                n_kind = KIND_ADVERT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_word <= r_mem[r_idx];
        end
        if (i_cmd.commit && n_learn) begin
            r_mem[r_count[IDX_W-1:0]] <= '{addr: r_item.src_addr, port: r_item.in_port};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= t_in_word'(i_in_data);
            r_cmd  <= i_in_cmd;
        end
        if (i_cmd.commit) begin
            r_out_kind                  <= n_kind;
            r_out_word.out_port_mask    <= n_mask;
            r_out_word.advert_root_id   <= n_root;
            r_out_word.advert_root_dist <= n_dist;
            r_out_word.parent_port      <= n_par;
            r_out_word.parent_valid     <= n_pknown;
            r_out_word.learned          <= n_learn;
            r_out_word.table_full       <= n_full;
            r_out_word.pad              <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx          <= '0;
            r_rd_vld       <= 1'b0;
            r_hit          <= 1'b0;
            r_known        <= 1'b0;
            r_target       <= '0;
            r_count        <= '0;
            r_ports_in_use <= PORTS_IN_USE_RST;
            r_root         <= NODE_ID_RST;
            r_dist         <= '0;
            r_par          <= '0;
            r_pknown       <= 1'b0;
            r_tree         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan;
            if (i_cmd.load) begin
                r_idx   <= '0;
                r_hit   <= 1'b0;
                r_known <= 1'b0;
            end else if (i_cmd.scan) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (r_rd_vld) begin
                if (r_rd_word.addr == r_item.src_addr && r_rd_word.port == r_item.in_port) begin
                    r_known <= 1'b1;
                end
                if (r_rd_word.addr == r_item.dst_addr) begin
                    r_hit    <= 1'b1;
                    r_target <= r_rd_word.port;
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_NODE_ID: begin
                        r_root   <= i_cfg_data;
                        r_dist   <= '0;
                        r_par    <= '0;
                        r_pknown <= 1'b0;
                    end
                    CFG_PORTS_IN_USE: begin
                        r_ports_in_use <= i_cfg_data[3:0];
                    end
                    default: begin
                        r_ports_in_use <= r_ports_in_use;
                    end
                endcase
            end else if (i_cmd.commit) begin
                r_root   <= n_root;
                r_dist   <= n_dist;
                r_par    <= n_par;
                r_pknown <= n_pknown;
                r_tree   <= n_tree;
                if (n_learn) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: src/learning_switch_spanning_tree_core.sv
// Top level of the learning switch core with spanning tree
`timescale 1ns / 1ps
// Usage:
//   Input channel (s_axis): one word per command. tuser carries the command:
//   data packet, tree packet received or send advert; the fourth code is
//   dropped without a result. tdata carries the packet and tree fields.
//   Output channel (m_axis): one result word per valid command; tuser carries
//   the result kind (unicast, flood, tree updated, advert).
//   Configuration: write node id (index 0) or ports in use (index 1) while idle.
// Sequence:
//   A data packet reads the address table one entry per cycle through a single
//   memory read port, entry_count entries, at most TABLE_ENTRIES; it then passes
//   the last-read and finish states to its result. With an empty table it goes
//   straight to the finish state, as do tree and advert commands. One command is
//   in flight at a time; tready is high only while idle, and a dropped word frees
//   the input in the next cycle.
// Reset:
//   Synchronous, active low. Table is empty, root is the node id, no parent,
//   no tree ports. The table memory is not cleared; the fill count guards it.
// Stall:
//   The result sits in an output register. The next command is accepted and
//   processed while it waits; its commit holds until the result is taken.

`include "learning_switch_spanning_tree_core_assert.svh"

module learning_switch_spanning_tree_core
    import lsst_pkg::*;
#(
    parameter int NUM_PORTS     = 8,
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // in_port[2:0], src_addr[10:3], dst_addr[18:11], heard_root_id[26:19],
    // heard_root_dist[34:27], sender_kind[36:35], child_flag[37], zero[39:38]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // command[1:0]
    input  logic [CMD_W-1:0]      i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // out_port_mask[7:0], advert_root_id[15:8], advert_root_dist[23:16],
    // parent_port[26:24], parent_valid[27], learned[28], table_full[29], zero[31:30]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // result_kind[1:0]
    output logic [1:0]            o_m_axis_tuser,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_out_word  w_out;
    logic       w_in_take;
    logic       w_learn_full;
    logic       w_out_tree;

    assign w_out        = o_m_axis_tdata;
    assign w_in_take    = i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser != CMD_NONE);
    assign w_learn_full = w_out.learned && w_out.table_full;
    assign w_out_tree   = o_m_axis_tvalid && (o_m_axis_tuser == KIND_TREE);

    lsst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lsst_dpath #(
        .NUM_PORTS     (NUM_PORTS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_cmd    (i_s_axis_tuser),
        .i_in_data   (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_kind  (o_m_axis_tuser),
        .o_out_data  (o_m_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

    `LSST_ASSERT_NEXT(a_busy_after_accept, w_in_take, !o_s_axis_tready, "ready after accept")
    `LSST_ASSERT_SAME(a_learn_full_excl, o_m_axis_tvalid, !w_learn_full, "learned with full")
    `LSST_ASSERT_SAME(a_tree_mask_zero, w_out_tree, w_out.out_port_mask == '0, "tree mask set")

endmodule
